@@ sv/rss_pkg.sv @@
// Package with codes, widths and reset values of the range switch sequencer.
package rss_pkg;

  localparam int unsigned ACTION_W = 2;
  localparam int unsigned RANGE_W  = 3;
  localparam int unsigned TIME_W   = 32;
  localparam int unsigned CFG_W    = 16;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned SAFETY_W = 2;

  typedef logic [ACTION_W-1:0]  action_t;
  typedef logic [RANGE_W-1:0]   range_t;
  typedef logic [TIME_W-1:0]    time_t;
  typedef logic [CFG_W-1:0]     cfg_word_t;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  typedef logic [STATUS_W-1:0]  status_t;
  typedef logic [PHASE_W-1:0]   phase_t;
  typedef logic [SAFETY_W-1:0]  safety_t;

  localparam action_t ACT_REQUEST = 2'd0;
  localparam action_t ACT_TICK    = 2'd1;
  localparam action_t ACT_DISABLE = 2'd2;

  localparam cfg_index_t REG_DEAD_TIME   = 1'd0;
  localparam cfg_index_t REG_SETTLE_TIME = 1'd1;

  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_INVALID = 2'd1;
  localparam status_t ST_BUSY    = 2'd2;

  localparam phase_t PH_DISABLED = 3'd0;
  localparam phase_t PH_DEAD     = 3'd1;
  localparam phase_t PH_SETTLE   = 3'd2;
  localparam phase_t PH_READY    = 3'd3;
  localparam phase_t PH_INVALID  = 3'd4;

  localparam safety_t SAFE_DISABLED = 2'd0;
  localparam safety_t SAFE_MOVING   = 2'd1;
  localparam safety_t SAFE_READY    = 2'd2;
  localparam safety_t SAFE_INVALID  = 2'd3;

  localparam range_t RANGE_MAX  = 3'd5;
  localparam range_t RANGE_NONE = 3'd6;

  localparam time_t HALF_SPAN = 32'h8000_0000;

  localparam cfg_word_t DEAD_TIME_RST   = 16'd2;
  localparam cfg_word_t SETTLE_TIME_RST = 16'd10;

endpackage

@@ sv/rss_ifs.sv @@
// Handshake interfaces for the event, result and register write channels.
interface rss_in_if;
  logic             valid;
  logic             ready;
  rss_pkg::action_t action;
  rss_pkg::range_t  range_id;
  rss_pkg::time_t   now_ms;

  modport source (output valid, output action, output range_id, output now_ms, input ready);
  modport sink   (input valid, input action, input range_id, input now_ms, output ready);
endinterface

interface rss_out_if;
  logic             valid;
  logic             ready;
  rss_pkg::status_t status;
  logic             drive_enable;
  rss_pkg::range_t  switch_address;
  rss_pkg::phase_t  fsm_state;
  rss_pkg::range_t  current_range;
  rss_pkg::range_t  requested_range;
  rss_pkg::safety_t safety_state;
  logic             is_ready;

  modport source (output valid, output status, output drive_enable, output switch_address,
                  output fsm_state, output current_range, output requested_range,
                  output safety_state, output is_ready, input ready);
  modport sink   (input valid, input status, input drive_enable, input switch_address,
                  input fsm_state, input current_range, input requested_range,
                  input safety_state, input is_ready, output ready);
endinterface

interface rss_cfg_if;
  logic                valid;
  logic                ready;
  rss_pkg::cfg_index_t index;
  rss_pkg::cfg_word_t  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

@@ sv/range_switch_sequencer.sv @@
// Range switch sequencer: event handling, timing registers and result register.
//
//   channel   dir   beat contents
//   in_bus    in    action, range_id, now_ms
//   out_bus   out   status, drive_enable, switch_address, fsm_state, current_range,
//                   requested_range, safety_state, is_ready
//   cfg_bus   in    index, data (0 dead time, 1 settle time)
//
// Each event beat is handled combinationally; its result enters the result register
// on the next cycle; one beat is taken every cycle unless the result stalls.
// The path is set by a 32-bit deadline subtract and the 32-bit deadline adds.
// A new beat is taken while the result register is empty or being read out.
// Synchronous active-low reset puts the switch in the disabled state, ranges invalid.
// Register writes are always taken.
module range_switch_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  rss_in_if.sink     in_bus,
  rss_out_if.source  out_bus,
  rss_cfg_if.sink    cfg_bus
);

  rss_pkg::cfg_word_t dead_time_r;
  rss_pkg::cfg_word_t settle_time_r;

  rss_pkg::phase_t phase_r, phase_nxt;
  rss_pkg::range_t range_now_r, range_now_nxt;
  rss_pkg::range_t range_wanted_r, range_wanted_nxt;
  rss_pkg::range_t mux_address_r, mux_address_nxt;
  rss_pkg::time_t  deadline_r, deadline_nxt;
  logic            enabled_r, enabled_nxt;
  rss_pkg::status_t status_nxt;
  rss_pkg::safety_t safety_nxt;

  logic            out_valid_r;
  rss_pkg::status_t out_status_r;
  logic            out_enable_r;
  rss_pkg::range_t out_address_r;
  rss_pkg::phase_t out_phase_r;
  rss_pkg::range_t out_current_r;
  rss_pkg::range_t out_requested_r;
  rss_pkg::safety_t out_safety_r;
  logic            out_is_ready_r;

  logic            in_fire;
  logic            due;
  rss_pkg::time_t  elapsed;

  assign cfg_bus.ready = 1'b1;
  assign in_bus.ready  = !out_valid_r || out_bus.ready;
  assign in_fire       = in_bus.valid && in_bus.ready;

  assign elapsed = in_bus.now_ms - deadline_r;
  assign due     = elapsed < rss_pkg::HALF_SPAN;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dead_time_r   <= rss_pkg::DEAD_TIME_RST;
      settle_time_r <= rss_pkg::SETTLE_TIME_RST;
    end else if (cfg_bus.valid) begin
      unique case (cfg_bus.index)
        rss_pkg::REG_DEAD_TIME:   dead_time_r   <= cfg_bus.data;
        rss_pkg::REG_SETTLE_TIME: settle_time_r <= cfg_bus.data;
        default: ;
      endcase
    end
  end

  always_comb begin
    phase_nxt        = phase_r;
    range_now_nxt    = range_now_r;
    range_wanted_nxt = range_wanted_r;
    mux_address_nxt  = mux_address_r;
    deadline_nxt     = deadline_r;
    enabled_nxt      = enabled_r;
    status_nxt       = rss_pkg::ST_OK;
    unique case (in_bus.action)
      rss_pkg::ACT_REQUEST: begin
        enabled_nxt = 1'b0;
        if (in_bus.range_id > rss_pkg::RANGE_MAX) begin
          phase_nxt        = rss_pkg::PH_INVALID;
          range_now_nxt    = rss_pkg::RANGE_NONE;
          range_wanted_nxt = rss_pkg::RANGE_NONE;
          status_nxt       = rss_pkg::ST_INVALID;
        end else begin
          mux_address_nxt  = in_bus.range_id;
          range_wanted_nxt = in_bus.range_id;
          phase_nxt        = rss_pkg::PH_DEAD;
          deadline_nxt     = in_bus.now_ms + rss_pkg::time_t'(dead_time_r);
          status_nxt       = rss_pkg::ST_BUSY;
        end
      end
      rss_pkg::ACT_TICK: begin
        if (phase_r == rss_pkg::PH_DEAD && due) begin
          enabled_nxt  = 1'b1;
          phase_nxt    = rss_pkg::PH_SETTLE;
          deadline_nxt = in_bus.now_ms + rss_pkg::time_t'(settle_time_r);
        end else if (phase_r == rss_pkg::PH_SETTLE && due) begin
          range_now_nxt = range_wanted_r;
          phase_nxt     = rss_pkg::PH_READY;
        end
      end
      rss_pkg::ACT_DISABLE: begin
        enabled_nxt   = 1'b0;
        phase_nxt     = rss_pkg::PH_DISABLED;
        range_now_nxt = rss_pkg::RANGE_NONE;
      end
      default: begin
        status_nxt = rss_pkg::ST_INVALID;
      end
    endcase

    unique case (phase_nxt)
      rss_pkg::PH_READY:    safety_nxt = enabled_nxt ? rss_pkg::SAFE_READY : rss_pkg::SAFE_INVALID;
      rss_pkg::PH_DISABLED: safety_nxt = rss_pkg::SAFE_DISABLED;
      rss_pkg::PH_DEAD,
      rss_pkg::PH_SETTLE:   safety_nxt = rss_pkg::SAFE_MOVING;
      default:              safety_nxt = rss_pkg::SAFE_INVALID;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= rss_pkg::PH_DISABLED;
      range_now_r    <= rss_pkg::RANGE_NONE;
      range_wanted_r <= rss_pkg::RANGE_NONE;
      mux_address_r  <= '0;
      deadline_r     <= '0;
      enabled_r      <= 1'b0;
    end else if (in_fire) begin
      phase_r        <= phase_nxt;
      range_now_r    <= range_now_nxt;
      range_wanted_r <= range_wanted_nxt;
      mux_address_r  <= mux_address_nxt;
      deadline_r     <= deadline_nxt;
      enabled_r      <= enabled_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      out_status_r    <= status_nxt;
      out_enable_r    <= enabled_nxt;
      out_address_r   <= mux_address_nxt;
      out_phase_r     <= phase_nxt;
      out_current_r   <= range_now_nxt;
      out_requested_r <= range_wanted_nxt;
      out_safety_r    <= safety_nxt;
      out_is_ready_r  <= (phase_nxt == rss_pkg::PH_READY) && enabled_nxt;
    end
  end

  assign out_bus.valid           = out_valid_r;
  assign out_bus.status          = out_status_r;
  assign out_bus.drive_enable    = out_enable_r;
  assign out_bus.switch_address  = out_address_r;
  assign out_bus.fsm_state       = out_phase_r;
  assign out_bus.current_range   = out_current_r;
  assign out_bus.requested_range = out_requested_r;
  assign out_bus.safety_state    = out_safety_r;
  assign out_bus.is_ready        = out_is_ready_r;

  // The enable is high exactly while settling or ready.
  a_enable_phase: assert property (@(posedge clk) disable iff (!rst_n)
    enabled_r == (phase_r == rss_pkg::PH_SETTLE || phase_r == rss_pkg::PH_READY))
    else $error("enable level does not match sequencer phase");

  a_ready_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == rss_pkg::PH_READY |-> range_now_r <= rss_pkg::RANGE_MAX)
    else $error("ready phase without a valid current range");

  a_addr_legal: assert property (@(posedge clk) disable iff (!rst_n)
    mux_address_r <= rss_pkg::RANGE_MAX)
    else $error("multiplexer address out of range");

  a_request_dead: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_bus.action == rss_pkg::ACT_REQUEST && in_bus.range_id <= rss_pkg::RANGE_MAX
    |=> phase_r == rss_pkg::PH_DEAD && out_valid_r && out_status_r == rss_pkg::ST_BUSY)
    else $error("valid request did not start dead time");

  a_no_stall_loss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |=> out_valid_r)
    else $error("pending result dropped");

endmodule

@@ bench/range_switch_sequencer_test.sv @@
// Self-checking testbench for the range switch sequencer: stimulus, timing setup and checks.
module range_switch_sequencer_test;
  timeunit 1ns;
  timeprecision 1ps;

  import rss_pkg::*;

  localparam action_t ACT_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 1000;
  localparam int ITEMS_PER_SETTING = 56;
  localparam int NUM_SETTINGS = 8;

  typedef struct packed {
    status_t status;
    logic    drive_enable;
    range_t  switch_address;
    phase_t  fsm_state;
    range_t  current_range;
    range_t  requested_range;
    safety_t safety_state;
    logic    is_ready;
  } switch_report_t;

  class switch_scoreboard;
    cfg_word_t dead_ms;
    cfg_word_t settle_ms;
    phase_t phase;
    range_t range_now;
    range_t range_wanted;
    range_t mux_addr;
    time_t due;
    logic enabled;
    switch_report_t expected_reports[$];
    int errors;
    int results_seen;
    int ready_results;
    int settings_seen;
    int action_count[4];

    function new();
      dead_ms = DEAD_TIME_RST;
      settle_ms = SETTLE_TIME_RST;
      phase = PH_DISABLED;
      range_now = RANGE_NONE;
      range_wanted = RANGE_NONE;
      mux_addr = '0;
      due = '0;
      enabled = 1'b0;
      errors = 0;
      results_seen = 0;
      ready_results = 0;
      settings_seen = 0;
      foreach (action_count[i]) action_count[i] = 0;
    endfunction

    function void note_config(cfg_index_t index, cfg_word_t data);
      if (index == REG_DEAD_TIME) begin
        dead_ms = data;
      end else if (index == REG_SETTLE_TIME) begin
        settle_ms = data;
        settings_seen++;
      end
    endfunction

    function void note_event(action_t act, range_t rid, time_t now);
      switch_report_t r;
      action_count[act]++;
      r.status = ST_OK;
      case (act)
        ACT_REQUEST: begin
          enabled = 1'b0;
          if (rid > RANGE_MAX) begin
            phase = PH_INVALID;
            range_now = RANGE_NONE;
            range_wanted = RANGE_NONE;
            r.status = ST_INVALID;
          end else begin
            mux_addr = rid;
            range_wanted = rid;
            phase = PH_DEAD;
            due = now + time_t'(dead_ms);
            r.status = ST_BUSY;
          end
        end
        ACT_TICK: begin
          if (phase == PH_DEAD && (now - due) < HALF_SPAN) begin
            enabled = 1'b1;
            phase = PH_SETTLE;
            due = now + time_t'(settle_ms);
          end else if (phase == PH_SETTLE && (now - due) < HALF_SPAN) begin
            range_now = range_wanted;
            phase = PH_READY;
          end
        end
        ACT_DISABLE: begin
          enabled = 1'b0;
          phase = PH_DISABLED;
          range_now = RANGE_NONE;
        end
        default: begin
          r.status = ST_INVALID;
        end
      endcase
      r.drive_enable = enabled;
      r.switch_address = mux_addr;
      r.fsm_state = phase;
      r.current_range = range_now;
      r.requested_range = range_wanted;
      case (phase)
        PH_READY: r.safety_state = enabled ? SAFE_READY : SAFE_INVALID;
        PH_DISABLED: r.safety_state = SAFE_DISABLED;
        PH_DEAD, PH_SETTLE: r.safety_state = SAFE_MOVING;
        default: r.safety_state = SAFE_INVALID;
      endcase
      r.is_ready = (phase == PH_READY) && enabled;
      expected_reports.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      $display("%0t: %s", $time, msg);
    endtask

    task check_report(switch_report_t got);
      switch_report_t want;
      results_seen++;
      if (got.is_ready === 1'b1) ready_results++;
      if (expected_reports.size() == 0) begin
        report($sformatf("result %0d arrived with no event pending", results_seen));
        return;
      end
      want = expected_reports.pop_front();
      if (got.status !== want.status)
        report($sformatf("result %0d: status %0d, expected %0d",
                         results_seen, got.status, want.status));
      if (got.drive_enable !== want.drive_enable)
        report($sformatf("result %0d: drive_enable %0d, expected %0d",
                         results_seen, got.drive_enable, want.drive_enable));
      if (got.switch_address !== want.switch_address)
        report($sformatf("result %0d: switch_address %0d, expected %0d",
                         results_seen, got.switch_address, want.switch_address));
      if (got.fsm_state !== want.fsm_state)
        report($sformatf("result %0d: fsm_state %0d, expected %0d",
                         results_seen, got.fsm_state, want.fsm_state));
      if (got.current_range !== want.current_range)
        report($sformatf("result %0d: current_range %0d, expected %0d",
                         results_seen, got.current_range, want.current_range));
      if (got.requested_range !== want.requested_range)
        report($sformatf("result %0d: requested_range %0d, expected %0d",
                         results_seen, got.requested_range, want.requested_range));
      if (got.safety_state !== want.safety_state)
        report($sformatf("result %0d: safety_state %0d, expected %0d",
                         results_seen, got.safety_state, want.safety_state));
      if (got.is_ready !== want.is_ready)
        report($sformatf("result %0d: is_ready %0d, expected %0d",
                         results_seen, got.is_ready, want.is_ready));
    endtask
  endclass

  logic clk;
  logic rst_n;

  rss_in_if  in_bus();
  rss_out_if out_bus();
  rss_cfg_if cfg_bus();

  range_switch_sequencer dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_bus),
    .out_bus (out_bus),
    .cfg_bus (cfg_bus)
  );

  switch_scoreboard sb = new();

  switch_report_t seen_report;
  cfg_word_t cur_dead;
  cfg_word_t cur_settle;
  cfg_word_t dead_choice[NUM_SETTINGS];
  cfg_word_t settle_choice[NUM_SETTINGS];
  logic [15:0] stall_mask;
  logic [3:0] stall_pos;
  int burst_left;
  int items_sent;
  int quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b1;
      stall_pos <= '0;
    end else begin
      out_bus.ready <= stall_mask[stall_pos];
      stall_pos <= stall_pos + 4'd1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_bus.valid && out_bus.ready) begin
        seen_report.status = out_bus.status;
        seen_report.drive_enable = out_bus.drive_enable;
        seen_report.switch_address = out_bus.switch_address;
        seen_report.fsm_state = out_bus.fsm_state;
        seen_report.current_range = out_bus.current_range;
        seen_report.requested_range = out_bus.requested_range;
        seen_report.safety_state = out_bus.safety_state;
        seen_report.is_ready = out_bus.is_ready;
        sb.check_report(seen_report);
      end
      if (in_bus.valid && in_bus.ready)
        sb.note_event(in_bus.action, in_bus.range_id, in_bus.now_ms);
      if (cfg_bus.valid && cfg_bus.ready)
        sb.note_config(cfg_bus.index, cfg_bus.data);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
        (cfg_bus.valid && cfg_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_event(action_t act, range_t rid, time_t now);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 3) == 0) begin
        gap = 0;
        burst_left = 30;
      end else begin
        gap = $urandom_range(0, 6);
        burst_left = $urandom_range(1, 12);
      end
      if (gap > 0) begin
        in_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_bus.valid <= 1'b1;
    in_bus.action <= act;
    in_bus.range_id <= rid;
    in_bus.now_ms <= now;
    do @(posedge clk); while (!in_bus.ready);
    burst_left--;
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_bus.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.expected_reports.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_timing(cfg_word_t dead, cfg_word_t settle);
    cfg_bus.valid <= 1'b1;
    cfg_bus.index <= REG_DEAD_TIME;
    cfg_bus.data <= dead;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.index <= REG_SETTLE_TIME;
    cfg_bus.data <= settle;
    do @(posedge clk); while (!cfg_bus.ready);
    cfg_bus.valid <= 1'b0;
    cur_dead = dead;
    cur_settle = settle;
  endtask

  // Ticks are aimed around the pending deadline so that most sequences
  // step through dead time and settling into the ready state.
  task automatic switch_sequence();
    time_t t;
    time_t due;
    int stage;
    int n_ticks;
    range_t rid;
    if ($urandom_range(0, 9) == 0) rid = range_t'($urandom_range(6, 7));
    else rid = range_t'($urandom_range(0, 5));
    if ($urandom_range(0, 3) == 0) t = 32'hFFFF_FFFF - $urandom_range(0, cur_dead + 4);
    else t = $urandom();
    send_event(ACT_REQUEST, rid, t);
    due = t + time_t'(cur_dead);
    stage = 0;
    n_ticks = $urandom_range(2, 7);
    repeat (n_ticks) begin
      case ($urandom_range(0, 7))
        0: t = due - $urandom_range(1, 3);
        1: t = due + HALF_SPAN;
        2: t = due + HALF_SPAN - 1;
        3: t = due + $urandom_range(1, 4);
        default: t = due;
      endcase
      if ($urandom_range(0, 19) == 0) begin
        send_event(ACT_DISABLE, range_t'($urandom_range(0, 7)), t);
        return;
      end
      if ($urandom_range(0, 24) == 0)
        send_event(ACT_UNUSED, range_t'($urandom_range(0, 7)), t);
      send_event(ACT_TICK, range_t'($urandom_range(0, 7)), t);
      if (stage < 2 && (t - due) < HALF_SPAN) begin
        due = t + time_t'(cur_settle);
        stage++;
      end
    end
  endtask

  initial begin
    int start_count;
    rst_n <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.action <= ACT_TICK;
    in_bus.range_id <= '0;
    in_bus.now_ms <= '0;
    cfg_bus.valid <= 1'b0;
    cfg_bus.index <= REG_DEAD_TIME;
    cfg_bus.data <= '0;
    stall_mask = 16'hFFFF;
    burst_left = 0;
    items_sent = 0;
    cur_dead = DEAD_TIME_RST;
    cur_settle = SETTLE_TIME_RST;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    stall_mask = 16'hB6D5;
    send_event(ACT_TICK,    3'd0, 32'h0000_0000);
    send_event(ACT_UNUSED,  3'd7, 32'hFFFF_FFFF);
    send_event(ACT_DISABLE, 3'd0, 32'h0000_0005);
    send_event(ACT_REQUEST, 3'd0, 32'hFFFF_FFFE);
    send_event(ACT_TICK,    3'd0, 32'hFFFF_FFFF);
    send_event(ACT_TICK,    3'd0, 32'h0000_0000);
    send_event(ACT_UNUSED,  3'd3, 32'h0000_0001);
    send_event(ACT_TICK,    3'd0, 32'h0000_0009);
    send_event(ACT_TICK,    3'd0, 32'h0000_000A);
    send_event(ACT_TICK,    3'd0, 32'h0000_000B);
    send_event(ACT_REQUEST, 3'd5, 32'h0000_0064);
    send_event(ACT_DISABLE, 3'd0, 32'h0000_0065);
    send_event(ACT_TICK,    3'd0, 32'h0000_00C8);
    send_event(ACT_REQUEST, 3'd6, 32'h0000_012C);
    send_event(ACT_TICK,    3'd0, 32'h0000_012D);
    send_event(ACT_REQUEST, 3'd7, 32'h0000_012E);
    send_event(ACT_REQUEST, 3'd3, 32'h7FFF_FFFF);
    send_event(ACT_TICK,    3'd7, 32'h0000_0001);
    send_event(ACT_TICK,    3'd0, 32'h0000_0000);
    send_event(ACT_REQUEST, 3'd4, 32'h0000_0005);
    send_event(ACT_TICK,    3'd0, 32'h0000_0007);
    send_event(ACT_TICK,    3'd0, 32'h0000_0011);
    send_event(ACT_DISABLE, 3'd7, 32'h0000_0014);
    send_event(ACT_REQUEST, 3'd2, 32'h0000_001E);
    send_event(ACT_TICK,    3'd0, 32'h0000_0020);
    send_event(ACT_TICK,    3'd0, 32'h0000_002A);

    dead_choice[0] = 16'd0;     settle_choice[0] = 16'd0;
    dead_choice[1] = 16'd1;     settle_choice[1] = 16'd1;
    dead_choice[2] = 16'hFFFF;  settle_choice[2] = 16'hFFFF;
    dead_choice[3] = 16'd3;     settle_choice[3] = 16'd7;
    dead_choice[4] = 16'hFFFF;  settle_choice[4] = 16'd0;
    dead_choice[5] = 16'd0;     settle_choice[5] = 16'hFFFF;
    dead_choice[6] = 16'($urandom());
    settle_choice[6] = 16'($urandom());
    dead_choice[7] = DEAD_TIME_RST;
    settle_choice[7] = SETTLE_TIME_RST;

    for (int k = 0; k < NUM_SETTINGS; k++) begin
      wait_for_results();
      write_timing(dead_choice[k], settle_choice[k]);
      if (k % 3 == 0) stall_mask = 16'hFFFF;
      else stall_mask = 16'($urandom()) | 16'h0001;
      start_count = items_sent;
      while (items_sent - start_count < ITEMS_PER_SETTING) begin
        if ($urandom_range(0, 5) == 0)
          send_event(action_t'($urandom_range(0, 3)), range_t'($urandom_range(0, 7)),
                     $urandom());
        else
          switch_sequence();
      end
    end

    wait_for_results();
    repeat (5) @(posedge clk);
    $display("Run covered %0d events: %0d requests, %0d ticks, %0d disables, %0d unused codes",
             items_sent, sb.action_count[ACT_REQUEST], sb.action_count[ACT_TICK],
             sb.action_count[ACT_DISABLE], sb.action_count[ACT_UNUSED]);
    $display("%0d results checked, %0d with the range ready, %0d timing settings",
             sb.results_seen, sb.ready_results, sb.settings_seen);
    if (sb.errors == 0 && sb.expected_reports.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ files.f @@
sv/rss_pkg.sv
sv/rss_ifs.sv
sv/range_switch_sequencer.sv
bench/range_switch_sequencer_test.sv
